/* hdl/relocatable_segment_address_decoder_macros.svh */
`ifndef RELOCATABLE_SEGMENT_ADDRESS_DECODER_MACROS_SVH
`define RELOCATABLE_SEGMENT_ADDRESS_DECODER_MACROS_SVH

// same-cycle implication
`define RSAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsad implication check failed");

// next-cycle implication
`define RSAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsad next-cycle check failed");

`endif

/* hdl/rsad_pkg.sv */
package rsad_pkg;

    localparam int WINDOW_COUNT_DEFAULT = 16;
    localparam int INDEX_W              = 4;
    localparam int ADDR_W               = 32;
    localparam int SIZE_W               = 2;
    localparam int RELOC_W              = 2;
    localparam int CFG_INDEX_W          = 2;
    localparam int QUEUE_DEPTH          = 2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_FETCH  = 2'd2,
        OP_SET_PC = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DECODE
    } cmd_kind_t;

    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_LONG = 2'd2;

    localparam logic [RELOC_W-1:0] RELOC_NONE   = 2'd0;
    localparam logic [RELOC_W-1:0] RELOC_MODULE = 2'd1;
    localparam logic [RELOC_W-1:0] RELOC_ROM    = 2'd2;
    localparam logic [RELOC_W-1:0] RELOC_RAM    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_MODULE_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROM_BASE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RAM_BASE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_PC    = 2'd3;

    typedef struct packed {
        opcode_t              opcode;
        logic [INDEX_W-1:0]   entry_index;
        logic [ADDR_W-1:0]    entry_base;
        logic [ADDR_W-1:0]    entry_mask;
        logic [RELOC_W-1:0]   entry_relocation;
        logic [ADDR_W-1:0]    address;
        logic [SIZE_W-1:0]    access_size;
    } in_item_t;

    typedef struct packed {
        logic                 hit;
        logic                 access_error;
        logic [INDEX_W-1:0]   segment_number;
        logic [ADDR_W-1:0]    local_offset;
        logic [ADDR_W-1:0]    decoded_address;
        logic [SIZE_W-1:0]    decoded_size;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [INDEX_W-1:0]   entry_index;
        logic [ADDR_W-1:0]    entry_base;
        logic [ADDR_W-1:0]    entry_mask;
        logic [RELOC_W-1:0]   entry_relocation;
        logic [ADDR_W-1:0]    address;
        logic [SIZE_W-1:0]    size;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* hdl/rsad_front.sv */
module rsad_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rsad_pkg::in_item_t     in_item,
    input  rsad_pkg::queue_status_t q_status,
    output logic                   push,
    output rsad_pkg::cmd_t         push_cmd
);
    import rsad_pkg::*;

    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] pc_next;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] fetch_addr;
    logic [ADDR_W-1:0] pc_step;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        // size code three behaves as long
        size       = (in_item.access_size > SIZE_LONG) ? SIZE_LONG : in_item.access_size;
        // byte fetch skips one byte before the fetched byte; pc still steps by two
        fetch_addr = (size == SIZE_BYTE) ? pc_reg + ADDR_W'(1) : pc_reg;
        pc_step    = (size == SIZE_LONG) ? ADDR_W'(4) : ADDR_W'(2);
        pc_next    = pc_reg;

        push_cmd                  = '0;
        push_cmd.kind             = CMD_NONE;
        push_cmd.entry_index      = in_item.entry_index;
        push_cmd.entry_base       = in_item.entry_base;
        push_cmd.entry_mask       = in_item.entry_mask;
        push_cmd.entry_relocation = in_item.entry_relocation;
        push_cmd.size             = size;

        case (in_item.opcode)
            OP_LOAD:
            begin
                push_cmd.kind = CMD_LOAD;
            end
            OP_DECODE:
            begin
                push_cmd.kind    = CMD_DECODE;
                push_cmd.address = in_item.address;
            end
            OP_FETCH:
            begin
                push_cmd.kind    = CMD_DECODE;
                push_cmd.address = fetch_addr;
                pc_next          = pc_reg + pc_step;
            end
            OP_SET_PC:
            begin
                pc_next = in_item.address;
            end
            default:
            begin
                push_cmd.kind = CMD_NONE;
            end
        endcase
    end

    // start pc is cleared by the same reset, so the counter restarts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else if (push)
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/rsad_queue.sv */
module rsad_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rsad_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output rsad_pkg::cmd_t          head,
    output rsad_pkg::queue_status_t status
);
    import rsad_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/rsad_back.sv */
module rsad_back #(
    parameter int WINDOW_COUNT = rsad_pkg::WINDOW_COUNT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [rsad_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rsad_pkg::ADDR_W-1:0]         cfg_data,
    input  rsad_pkg::queue_status_t             q_status,
    input  rsad_pkg::cmd_t                      head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rsad_pkg::out_item_t                 out_item
);
    import rsad_pkg::*;

    // only entries reachable by the entry index field are kept
    localparam int ENTRY_COUNT = (WINDOW_COUNT < (1 << INDEX_W)) ? WINDOW_COUNT : (1 << INDEX_W);
    localparam int ENTRY_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    logic [ADDR_W-1:0]      module_reloc_reg;
    logic [ADDR_W-1:0]      rom_reloc_reg;
    logic [ADDR_W-1:0]      ram_reloc_reg;

    logic [ENTRY_COUNT-1:0] valid_reg;
    logic [ADDR_W-1:0]      origin_reg [ENTRY_COUNT];
    logic [ADDR_W-1:0]      mask_reg   [ENTRY_COUNT];
    logic [RELOC_W-1:0]     reloc_reg  [ENTRY_COUNT];

    logic                   m_valid_reg;
    logic                   m_decode_reg;
    logic [ADDR_W-1:0]      m_addr_reg;
    logic [SIZE_W-1:0]      m_size_reg;
    logic [ENTRY_COUNT-1:0] m_match_reg;

    logic                   out_valid_reg;
    out_item_t              out_item_reg;

    logic                   out_free;
    logic                   m_advance;
    logic                   load_now;
    logic [ENTRY_COUNT-1:0] match;
    logic [ADDR_W-1:0]      reloc_value [ENTRY_COUNT];
    logic [ENTRY_W-1:0]     hit_idx;
    logic                   hit;
    out_item_t              result;

    assign out_free  = !out_valid_reg || out_ready;
    assign m_advance = m_valid_reg && out_free;
    assign pop       = !q_status.empty && (!m_valid_reg || out_free);
    assign load_now  = pop && (head.kind == CMD_LOAD)
                       && ({1'b0, head.entry_index} < (INDEX_W + 1)'(ENTRY_COUNT));
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // window compare against the queue head
    always_comb
    begin
        for (int k = 0; k < ENTRY_COUNT; k++)
        begin
            case (reloc_reg[k])
                RELOC_MODULE: reloc_value[k] = module_reloc_reg;
                RELOC_ROM:    reloc_value[k] = rom_reloc_reg;
                RELOC_RAM:    reloc_value[k] = ram_reloc_reg;
                default:      reloc_value[k] = '0;
            endcase
            match[k] = valid_reg[k]
                       && ((head.address & mask_reg[k]) == (reloc_value[k] + origin_reg[k]));
        end
    end

    // lowest matching entry; offset is the address bits outside the mask
    always_comb
    begin
        hit_idx = '0;
        for (int k = ENTRY_COUNT - 1; k >= 0; k--)
        begin
            if (m_match_reg[k])
            begin
                hit_idx = ENTRY_W'(k);
            end
        end
        hit    = |m_match_reg;
        result = '0;
        if (m_decode_reg)
        begin
            result.hit             = hit;
            result.access_error    = !hit;
            result.decoded_address = m_addr_reg;
            result.decoded_size    = m_size_reg;
            if (hit)
            begin
                result.segment_number = INDEX_W'(hit_idx);
                result.local_offset   = m_addr_reg & ~mask_reg[hit_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_reloc_reg <= '0;
            rom_reloc_reg    <= '0;
            ram_reloc_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODULE_BASE: module_reloc_reg <= cfg_data;
                REG_ROM_BASE:    rom_reloc_reg    <= cfg_data;
                REG_RAM_BASE:    ram_reloc_reg    <= cfg_data;
                REG_START_PC:    ;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load_now)
        begin
            valid_reg[head.entry_index[ENTRY_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_now)
        begin
            origin_reg[head.entry_index[ENTRY_W-1:0]] <= head.entry_base;
            mask_reg[head.entry_index[ENTRY_W-1:0]]   <= head.entry_mask;
            reloc_reg[head.entry_index[ENTRY_W-1:0]]  <= head.entry_relocation;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_advance)
            begin
                m_valid_reg <= 1'b0;
            end
            if (m_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_decode_reg <= (head.kind == CMD_DECODE);
            m_addr_reg   <= head.address;
            m_size_reg   <= head.size;
            m_match_reg  <= match;
        end
        if (m_advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

/* hdl/relocatable_segment_address_decoder.sv */
// channel   handshake               payload
// in        in_valid / in_ready     in_item (opcode, entry fields, address, size)
// out       out_valid / out_ready   out_item (hit, error, segment, offsets, size)
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// each transaction produces one result: the queue head is compared against every window
// into the match register, and the lowest hit is picked into the output register
// the back end takes one queue entry per cycle while its output register drains
// cfg_ready is always high; start pc reads as zero after every reset
// reset clears the window valid bits, relocation registers and program counter
// a stalled output holds the back end and the two-entry queue takes up the slack
`include "relocatable_segment_address_decoder_macros.svh"

module relocatable_segment_address_decoder #(
    parameter int WINDOW_COUNT = rsad_pkg::WINDOW_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rsad_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rsad_pkg::out_item_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rsad_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rsad_pkg::ADDR_W-1:0]       cfg_data
);
    import rsad_pkg::*;

    queue_status_t q_status;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;

    assign cfg_ready = 1'b1;

    rsad_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rsad_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    rsad_back #(
        .WINDOW_COUNT (WINDOW_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `RSAD_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, !q_status.empty)
    `RSAD_ASSERT_NXT(a_push_fills, clk, rst_n, push && q_status.empty, !q_status.empty)
    `RSAD_ASSERT_IMP(a_size_clamped, clk, rst_n, out_valid, out_item.decoded_size <= SIZE_LONG)
    `RSAD_ASSERT_IMP(a_miss_clean, clk, rst_n, out_valid && out_item.access_error,
        !out_item.hit && (out_item.segment_number == '0) && (out_item.local_offset == '0))

endmodule
